@@ src/lrc_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the log record checker.
package lrc_pkg;

    // Reflected CRC-32 polynomial; CRC_TABLE_1 is entry 1 of the matching byte table.
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_TABLE_1   = 32'h7707_3096;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] LIMIT_DEFAULT = 32'd64 * 32'd1024 * 32'd1024;
    localparam logic [7:0]  BYTE_MASK     = 8'hFF;

    // Header layout: check word at 0..3, type at 4, key length 5..8, value length 9..12
    localparam logic [3:0] HDR_TYPE_POS  = 4'd4;
    localparam logic [3:0] HDR_KEY_LAST  = 4'd8;
    localparam logic [3:0] HDR_LAST      = 4'd12;

    localparam logic [1:0] VERDICT_GOOD     = 2'd0;
    localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
    localparam logic [1:0] VERDICT_LENGTH   = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_KEY    = 2'd1,
        PH_VALUE  = 2'd2,
        PH_HALT   = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  hdr_pos;
        logic [31:0] check_word;
        logic [7:0]  kind_byte;
        logic [31:0] key_count;
        logic [31:0] value_count;
        logic [31:0] bytes_left;
        logic [31:0] running_crc;
    } t_state;

    typedef struct packed {
        logic        byte_valid;
        logic        in_value;
        logic [7:0]  data_byte;
        logic        last_of_record;
        logic [7:0]  record_type;
        logic [1:0]  verdict;
        logic [31:0] key_length;
        logic [31:0] value_length;
    } t_result;

    // One byte of the reflected CRC, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b & BYTE_MASK};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

@@ src/lrc_step.sv @@
// Next-state and result logic for one log byte of the record checker.
module lrc_step (
    input  lrc_pkg::t_state  i_state,
    input  logic [31:0]      i_length_limit,
    input  logic [7:0]       i_log_byte,
    input  logic             i_first_of_log,
    output lrc_pkg::t_state  o_state,
    output logic             o_res_valid,
    output lrc_pkg::t_result o_result
);

    lrc_pkg::t_state st;
    lrc_pkg::t_state nx;
    logic            finish;
    logic [31:0]     left_dec;

    always_comb begin
        st = i_state;
        // a start mark abandons any partial record and clears the halt
        if (i_first_of_log) begin
            st.phase       = lrc_pkg::PH_HEADER;
            st.hdr_pos     = '0;
            st.running_crc = lrc_pkg::CRC_INIT;
        end

        nx          = st;
        finish      = 1'b0;
        left_dec    = st.bytes_left - 32'd1;
        o_res_valid = 1'b0;
        o_result    = '0;

        unique case (st.phase)
            lrc_pkg::PH_HALT: begin
                // bytes are dropped
            end
            lrc_pkg::PH_HEADER: begin
                if (st.hdr_pos < lrc_pkg::HDR_TYPE_POS) begin
                    nx.check_word = {i_log_byte, st.check_word[31:8]};
                end else begin
                    nx.running_crc = lrc_pkg::crc_byte(st.running_crc, i_log_byte);
                    if (st.hdr_pos == lrc_pkg::HDR_TYPE_POS) begin
                        nx.kind_byte = i_log_byte;
                    end else if (st.hdr_pos <= lrc_pkg::HDR_KEY_LAST) begin
                        nx.key_count = {i_log_byte, st.key_count[31:8]};
                    end else begin
                        nx.value_count = {i_log_byte, st.value_count[31:8]};
                    end
                end
                if (st.hdr_pos != lrc_pkg::HDR_LAST) begin
                    nx.hdr_pos = st.hdr_pos + 4'd1;
                end else begin
                    nx.hdr_pos = '0;
                    if (nx.key_count > i_length_limit || nx.value_count > i_length_limit) begin
                        nx.phase                = lrc_pkg::PH_HALT;
                        o_res_valid             = 1'b1;
                        o_result.last_of_record = 1'b1;
                        o_result.verdict        = lrc_pkg::VERDICT_LENGTH;
                    end else if (nx.key_count != '0) begin
                        nx.phase      = lrc_pkg::PH_KEY;
                        nx.bytes_left = nx.key_count;
                    end else if (nx.value_count != '0) begin
                        nx.phase      = lrc_pkg::PH_VALUE;
                        nx.bytes_left = nx.value_count;
                    end else begin
                        finish      = 1'b1;
                        o_res_valid = 1'b1;
                    end
                end
            end
            lrc_pkg::PH_KEY, lrc_pkg::PH_VALUE: begin
                nx.running_crc      = lrc_pkg::crc_byte(st.running_crc, i_log_byte);
                nx.bytes_left       = left_dec;
                o_res_valid         = 1'b1;
                o_result.byte_valid = 1'b1;
                o_result.in_value   = (st.phase == lrc_pkg::PH_VALUE);
                o_result.data_byte  = i_log_byte;
                if (left_dec == '0) begin
                    if (st.phase == lrc_pkg::PH_KEY && st.value_count != '0) begin
                        nx.phase      = lrc_pkg::PH_VALUE;
                        nx.bytes_left = st.value_count;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // end of record: compare finished CRC against the stored one
        if (finish) begin
            o_result.last_of_record = 1'b1;
            if (~nx.running_crc == nx.check_word) begin
                o_result.verdict = lrc_pkg::VERDICT_GOOD;
                nx.phase         = lrc_pkg::PH_HEADER;
            end else begin
                o_result.verdict = lrc_pkg::VERDICT_MISMATCH;
                nx.phase         = lrc_pkg::PH_HALT;
            end
            nx.hdr_pos     = '0;
            nx.running_crc = lrc_pkg::CRC_INIT;
        end

        o_result.record_type  = nx.kind_byte;
        o_result.key_length   = nx.key_count;
        o_result.value_length = nx.value_count;
        o_state               = nx;
    end

endmodule

@@ src/log_record_checker.sv @@
// Top level of the log record checker: state, config register and result register.
//
// Checks a stream of length-prefixed log records, one byte per transfer. Each record is a
// 13-byte header (stored CRC, type, key length, value length, little-endian) followed by the
// key and value bytes, which are passed out tagged by section. A standard reflected CRC-32
// runs over everything after the stored CRC; the last byte of a record carries the verdict.
// A length over i_cfg_wr_data's limit or a CRC mismatch halts the block, dropping bytes until
// a byte arrives with i_first_of_log set. Rate: one byte per cycle while o_in_stall is low;
// results are registered, each in the cycle after its byte is taken; the eight-step CRC byte
// update and the 32-bit length compares are combinational. Header bytes other than the last
// give no output transfer. The limit register may be written only while the block is idle.
module log_record_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_log_byte,
    input  logic        i_first_of_log,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_byte_valid,
    output logic        o_in_value,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_record,
    output logic [7:0]  o_record_type,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_key_length,
    output logic [31:0] o_value_length
);

    lrc_pkg::t_state  r_state;
    lrc_pkg::t_state  n_state;
    lrc_pkg::t_result r_out;
    lrc_pkg::t_result step_res;
    logic             step_valid;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [31:0]      r_length_limit;
    logic             accept;

    lrc_step u_step (
        .i_state        (r_state),
        .i_length_limit (r_length_limit),
        .i_log_byte     (i_log_byte),
        .i_first_of_log (i_first_of_log),
        .o_state        (n_state),
        .o_res_valid    (step_valid),
        .o_result       (step_res)
    );

    // input is held off only while a result waits and the sink stalls
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign n_out_valid = accept ? step_valid : (r_out_valid & i_out_stall);

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_limit <= lrc_pkg::LIMIT_DEFAULT;
        end else if (i_cfg_wr_en) begin
            r_length_limit <= i_cfg_wr_data;
        end
    end

    // record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: lrc_pkg::PH_HEADER, hdr_pos: '0, check_word: '0,
                         kind_byte: '0, key_count: '0, value_count: '0, bytes_left: '0,
                         running_crc: lrc_pkg::CRC_INIT};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step_valid) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_valid     = r_out.byte_valid;
    assign o_in_value       = r_out.in_value;
    assign o_data_byte      = r_out.data_byte;
    assign o_last_of_record = r_out.last_of_record;
    assign o_record_type    = r_out.record_type;
    assign o_verdict        = r_out.verdict;
    assign o_key_length     = r_out.key_length;
    assign o_value_length   = r_out.value_length;

    // halted block drops bytes without a start mark
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state.phase == lrc_pkg::PH_HALT && !i_first_of_log) |-> !step_valid)
        else $error("result produced while halted");

    // a bad verdict leaves the block halted
    a_bad_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && step_valid && step_res.verdict != lrc_pkg::VERDICT_GOOD)
        |=> r_state.phase == lrc_pkg::PH_HALT)
        else $error("bad verdict without halt");

    // mid-record results carry a good verdict
    a_mid_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_record) |-> o_verdict == lrc_pkg::VERDICT_GOOD)
        else $error("verdict on non-final result");

    // body phases always have bytes still to come
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == lrc_pkg::PH_KEY || r_state.phase == lrc_pkg::PH_VALUE)
        |-> r_state.bytes_left != '0)
        else $error("body phase with no bytes left");

    // header position only moves in the header phase
    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != lrc_pkg::PH_HEADER) |-> r_state.hdr_pos == '0)
        else $error("header position outside header phase");

endmodule

@@ tb/tb_log_record_checker.sv @@
// Self-checking testbench for the log record checker: directed and random record streams.
`timescale 1ns / 1ps

module tb_log_record_checker;

    localparam int DIR_ROWS = 29;
    localparam int SETTLE   = 4;
    localparam int HDR_LEN  = 13;

    // Directed rows either defer to the decoder or carry a typed expectation
    typedef enum logic [1:0] {
        PIN_MODEL,
        PIN_QUIET,
        PIN_OVER
    } t_pin;

    typedef struct packed {
        logic [7:0] b;
        logic       f;
        t_pin       pin;
        logic       fill;
    } t_row;

    // Header with an all-ones key length after reset: length verdict, nothing else
    localparam lrc_pkg::t_result DIRECTED_OVER = {1'b0, 1'b0, 8'h00, 1'b1, 8'hFF,
                                                  lrc_pkg::VERDICT_LENGTH,
                                                  32'hFFFF_FFFF, 32'h0000_0000};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'h0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_log_byte = 8'h00;
    logic        i_first_of_log = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_byte_valid;
    logic        o_in_value;
    logic [7:0]  o_data_byte;
    logic        o_last_of_record;
    logic [7:0]  o_record_type;
    logic [1:0]  o_verdict;
    logic [31:0] o_key_length;
    logic [31:0] o_value_length;

    // Decoder state, kept apart from the block
    lrc_pkg::t_phase rec_phase;
    logic [3:0]      hdr_idx;
    logic [31:0]     stored_sum;
    logic [7:0]      rec_kind;
    logic [31:0]     key_len_q;
    logic [31:0]     val_len_q;
    logic [31:0]     remain;
    logic [31:0]     crc_acc;
    logic [31:0]     len_limit;

    lrc_pkg::t_result due_outputs[$];
    int               mismatch_count = 0;
    int               sent_count = 0;
    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;
    int               hold_request = 0;

    log_record_checker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_log_byte      (i_log_byte),
        .i_first_of_log  (i_first_of_log),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_byte_valid    (o_byte_valid),
        .o_in_value      (o_in_value),
        .o_data_byte     (o_data_byte),
        .o_last_of_record(o_last_of_record),
        .o_record_type   (o_record_type),
        .o_verdict       (o_verdict),
        .o_key_length    (o_key_length),
        .o_value_length  (o_value_length)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Bitwise reflected CRC-32 update for one byte
    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        int k;
        c = acc ^ {24'h0, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ lrc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic lrc_pkg::t_result make_out(input logic bv, input logic iv,
                                                  input logic [7:0] d, input logic last,
                                                  input logic [1:0] verdict);
        return {bv, iv, d, last, rec_kind, verdict, key_len_q, val_len_q};
    endfunction

    // End of record: compare sums, pick the next phase, rearm the CRC
    function automatic logic [1:0] close_record();
        logic [1:0] v;
        v = (~crc_acc == stored_sum) ? lrc_pkg::VERDICT_GOOD : lrc_pkg::VERDICT_MISMATCH;
        rec_phase = (v == lrc_pkg::VERDICT_GOOD) ? lrc_pkg::PH_HEADER : lrc_pkg::PH_HALT;
        hdr_idx = '0;
        crc_acc = lrc_pkg::CRC_INIT;
        return v;
    endfunction

    task automatic reset_decoder();
        len_limit = lrc_pkg::LIMIT_DEFAULT;
        rec_phase = lrc_pkg::PH_HEADER;
        hdr_idx = '0;
        stored_sum = '0;
        rec_kind = '0;
        key_len_q = '0;
        val_len_q = '0;
        remain = '0;
        crc_acc = lrc_pkg::CRC_INIT;
    endtask

    // Walks one log byte through the record format; at most one output
    task automatic decode_log_byte(input logic [7:0] b, input logic f,
                                   output bit has_out, output lrc_pkg::t_result out);
        logic       iv;
        logic [1:0] v;
        has_out = 1'b0;
        out = '0;
        if (f) begin
            rec_phase = lrc_pkg::PH_HEADER;
            hdr_idx = '0;
            crc_acc = lrc_pkg::CRC_INIT;
        end
        if (rec_phase == lrc_pkg::PH_HEADER) begin
            if (hdr_idx < lrc_pkg::HDR_TYPE_POS) begin
                stored_sum = {b, stored_sum[31:8]};
            end else begin
                crc_acc = crc32_step(crc_acc, b);
                if (hdr_idx == lrc_pkg::HDR_TYPE_POS) rec_kind = b;
                else if (hdr_idx <= lrc_pkg::HDR_KEY_LAST) key_len_q = {b, key_len_q[31:8]};
                else val_len_q = {b, val_len_q[31:8]};
            end
            if (hdr_idx != lrc_pkg::HDR_LAST) begin
                hdr_idx = hdr_idx + 4'd1;
            end else begin
                hdr_idx = '0;
                if (key_len_q > len_limit || val_len_q > len_limit) begin
                    rec_phase = lrc_pkg::PH_HALT;
                    has_out = 1'b1;
                    out = make_out(1'b0, 1'b0, 8'h00, 1'b1, lrc_pkg::VERDICT_LENGTH);
                end else if (key_len_q != 32'd0) begin
                    rec_phase = lrc_pkg::PH_KEY;
                    remain = key_len_q;
                end else if (val_len_q != 32'd0) begin
                    rec_phase = lrc_pkg::PH_VALUE;
                    remain = val_len_q;
                end else begin
                    v = close_record();
                    has_out = 1'b1;
                    out = make_out(1'b0, 1'b0, 8'h00, 1'b1, v);
                end
            end
        end else if (rec_phase != lrc_pkg::PH_HALT) begin
            crc_acc = crc32_step(crc_acc, b);
            remain = remain - 32'd1;
            has_out = 1'b1;
            iv = (rec_phase == lrc_pkg::PH_VALUE);
            if (rec_phase == lrc_pkg::PH_KEY && remain == 32'd0 && val_len_q != 32'd0) begin
                rec_phase = lrc_pkg::PH_VALUE;
                remain = val_len_q;
                out = make_out(1'b1, 1'b0, b, 1'b0, lrc_pkg::VERDICT_GOOD);
            end else if (remain != 32'd0) begin
                out = make_out(1'b1, iv, b, 1'b0, lrc_pkg::VERDICT_GOOD);
            end else begin
                v = close_record();
                out = make_out(1'b1, iv, b, 1'b1, v);
            end
        end
    endtask

    // Offer one byte, hold it until the transfer, then log what it should cause
    task automatic send_item(input logic [7:0] b, input logic f, input bit pinned,
                             input bit pinned_out, input lrc_pkg::t_result pinned_res);
        bit               has_out;
        lrc_pkg::t_result out;
        bit               live;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_log_byte <= b;
        i_first_of_log <= f;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        live = f || (rec_phase != lrc_pkg::PH_HALT);
        decode_log_byte(b, f, has_out, out);
        if (pinned) begin
            if (pinned_out) due_outputs = {due_outputs, pinned_res};
        end else if (has_out) begin
            due_outputs = {due_outputs, out};
        end
        if (live) sent_count++;
    endtask

    // Sender pauses until every expected output has come out
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        len_limit = v;
    endtask

    function automatic t_row directed_row(input int idx);
        t_row r;
        case (idx)
            0, 1, 2, 3:          r = '{8'h00, 1'b0, PIN_QUIET, 1'b0}; // stored check, no start mark
            4, 5, 6, 7, 8:       r = '{8'hFF, 1'b0, PIN_QUIET, 1'b0}; // type, key length all ones
            9, 10, 11:           r = '{8'h00, 1'b0, PIN_QUIET, 1'b0};
            12:                  r = '{8'h00, 1'b0, PIN_OVER,  1'b0};
            13:                  r = '{8'hA5, 1'b0, PIN_QUIET, 1'b0}; // dropped while halted
            14:                  r = '{8'h00, 1'b1, PIN_QUIET, 1'b1}; // new log, check filled in
            15, 16, 17, 18:      r = '{8'h00, 1'b0, PIN_QUIET, 1'b0};
            19, 23:              r = '{8'h01, 1'b0, PIN_QUIET, 1'b0}; // one key, one value byte
            20, 21, 22, 24, 25:  r = '{8'h00, 1'b0, PIN_QUIET, 1'b0};
            26:                  r = '{8'h00, 1'b0, PIN_QUIET, 1'b0};
            27:                  r = '{8'h00, 1'b0, PIN_MODEL, 1'b0};
            default:             r = '{8'hFF, 1'b0, PIN_MODEL, 1'b0};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] fitting_len();
        logic [31:0] top;
        top = (len_limit < 32'd6) ? len_limit : 32'd6;
        if ($urandom_range(9) == 0 && len_limit <= 32'd12) return len_limit;
        return $urandom_range(top, 0);
    endfunction

    function automatic logic [31:0] any_fitting_len();
        if (len_limit == 32'hFFFF_FFFF) return $urandom;
        return $urandom % (len_limit + 32'd1);
    endfunction

    function automatic logic [31:0] over_len();
        logic [31:0] v;
        v = $urandom;
        if (v <= len_limit) v = len_limit + 32'd1;
        return v;
    endfunction

    // One record: header with computed check (optionally damaged), then body bytes
    task automatic send_record(input bit start, input logic [31:0] klen, input logic [31:0] vlen,
                               input int hdr_n, input int body_n, input logic [31:0] flip);
        logic [7:0]  kind;
        logic [7:0]  hdr[0:12];
        logic [7:0]  body[$];
        logic [31:0] sum;
        int          n;
        kind = 8'($urandom);
        sum = crc32_step(lrc_pkg::CRC_INIT, kind);
        for (n = 0; n < 4; n++) sum = crc32_step(sum, klen[8*n +: 8]);
        for (n = 0; n < 4; n++) sum = crc32_step(sum, vlen[8*n +: 8]);
        for (n = 0; n < body_n; n++) begin
            body = {body, 8'($urandom)};
            sum = crc32_step(sum, body[n]);
        end
        sum = ~sum ^ flip;
        for (n = 0; n < 4; n++) begin
            hdr[n] = sum[8*n +: 8];
            hdr[5 + n] = klen[8*n +: 8];
            hdr[9 + n] = vlen[8*n +: 8];
        end
        hdr[4] = kind;
        for (n = 0; n < hdr_n; n++) send_item(hdr[n], start && n == 0, 1'b0, 1'b0, '0);
        for (n = 0; n < body_n; n++) send_item(body[n], 1'b0, 1'b0, 1'b0, '0);
    endtask

    // Mostly good records; damaged checks, long lengths, cut records and noise between
    task automatic random_records(input int count);
        int          target;
        int          pick;
        int          hdr_n;
        int          body_n;
        int          n;
        bit          start;
        bit          need_start;
        logic [31:0] kl;
        logic [31:0] vl;
        logic [31:0] flip;
        longint      total;
        target = sent_count + count;
        need_start = 1'b1;
        while (sent_count < target) begin
            pick = $urandom_range(99);
            start = need_start || ($urandom_range(3) == 0);
            need_start = 1'b0;
            kl = fitting_len();
            vl = fitting_len();
            flip = '0;
            hdr_n = HDR_LEN;
            body_n = int'(kl + vl);
            if (pick >= 94) begin
                // stray bytes: a partial bogus header, or dropped while halted
                n = $urandom_range(6, 1);
                repeat (n) send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
                need_start = 1'b1;
            end else begin
                if (pick >= 70 && pick < 80) begin
                    flip = ($urandom_range(1) == 0) ? (32'h1 << $urandom_range(31))
                                                    : ($urandom | 32'h1);
                    need_start = 1'b1;
                end else if (pick >= 80 && pick < 88 && len_limit != 32'hFFFF_FFFF) begin
                    n = $urandom_range(2);
                    if (n != 1) kl = over_len();
                    if (n != 0) vl = over_len();
                    body_n = 0;
                    need_start = 1'b1;
                end else if (pick >= 88 && pick < 94) begin
                    // record abandoned by the next start of log
                    kl = any_fitting_len();
                    vl = any_fitting_len();
                    total = longint'(kl) + longint'(vl);
                    if ($urandom_range(1) == 1) hdr_n = $urandom_range(12, 1);
                    body_n = 0;
                    if (hdr_n == HDR_LEN && total != 0)
                        body_n = $urandom_range((total > 4) ? 3 : int'(total - 1));
                    need_start = 1'b1;
                end
                send_record(start, kl, vl, hdr_n, body_n, flip);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_output(input lrc_pkg::t_result got);
        lrc_pkg::t_result want;
        if (due_outputs.size() == 0) begin
            $display("%0t: output transfer with nothing expected, got %0h", $time, got);
            mismatch_count++;
        end else begin
            want = due_outputs.pop_front();
            check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            check_field("in_value", 32'(want.in_value), 32'(got.in_value));
            check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            check_field("last_of_record", 32'(want.last_of_record),
                        32'(got.last_of_record));
            check_field("record_type", 32'(want.record_type), 32'(got.record_type));
            check_field("verdict", 32'(want.verdict), 32'(got.verdict));
            check_field("key_length", want.key_length, got.key_length);
            check_field("value_length", want.value_length, got.value_length);
        end
    endtask

    // Output side: check each transfer, then pick the next stall
    initial begin
        lrc_pkg::t_result got;
        int               hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got = {o_byte_valid, o_in_value, o_data_byte, o_last_of_record, o_record_type,
                       o_verdict, o_key_length, o_value_length};
                check_output(got);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Main sequence
    initial begin
        int          i;
        int          k;
        int          fill_at;
        t_row        row;
        t_row        peek;
        logic [31:0] sum;
        logic [31:0] fill_word;
        reset_decoder();
        fill_at = -1;
        fill_word = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; the check word of the second record is computed here
        for (i = 0; i < DIR_ROWS; i++) begin
            row = directed_row(i);
            if (row.fill) begin
                sum = lrc_pkg::CRC_INIT;
                for (k = i + 4; k < DIR_ROWS; k++) begin
                    peek = directed_row(k);
                    sum = crc32_step(sum, peek.b);
                end
                fill_word = ~sum;
                fill_at = i;
            end
            if (fill_at >= 0 && i - fill_at < 4) row.b = fill_word[8*(i - fill_at) +: 8];
            send_item(row.b, row.f, row.pin != PIN_MODEL, row.pin == PIN_OVER, DIRECTED_OVER);
        end

        // Default limit, no idling; long output hold, then a full drain mid-stream
        random_records(120);
        hold_request = 40;
        random_records(60);
        wait_for_idle();
        random_records(80);
        wait_for_idle();

        write_limit(32'h0000_0000);
        sender_idle_pct = 60;
        random_records(260);
        wait_for_idle();

        write_limit(32'hFFFF_FFFF);
        sender_idle_pct = 0;
        receiver_stall_pct = 60;
        random_records(260);
        wait_for_idle();

        write_limit(32'd3);
        sender_idle_pct = 37;
        receiver_stall_pct = 37;
        random_records(260);
        wait_for_idle();

        write_limit($urandom);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        random_records(130);
        sender_idle_pct = 37;
        receiver_stall_pct = 37;
        random_records(130);
        wait_for_idle();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit
    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
